@@ hw/rtl/adaptive_idw_hole_fill_defines.svh @@
// Assertion macros shared by the hole-fill RTL.
`ifndef ADAPTIVE_IDW_HOLE_FILL_DEFINES_SVH
`define ADAPTIVE_IDW_HOLE_FILL_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AIHF_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define AIHF_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/aihf_pkg.sv @@
// Shared types, constants and functions of the hole-fill block.
package aihf_pkg;

  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned REQ_W   = 2;

  localparam int unsigned DEF_MAX_ROWS   = 512;
  localparam int unsigned DEF_MAX_COLS   = 1024;
  localparam int unsigned DEF_MAX_WINDOW = 15;

  // Configuration register widths and reset values.
  localparam int unsigned ROWS_REG_W  = 10;
  localparam int unsigned COLS_REG_W  = 11;
  localparam int unsigned LIMIT_REG_W = 4;
  localparam int unsigned WIN_REG_W   = 4;

  localparam logic [ROWS_REG_W-1:0]  ROWS_RST  = 10'd512;
  localparam logic [COLS_REG_W-1:0]  COLS_RST  = 11'd720;
  localparam logic [LIMIT_REG_W-1:0] LIMIT_RST = 4'd1;
  localparam logic [WIN_REG_W-1:0]   LWIN_RST  = 4'd15;
  localparam logic [WIN_REG_W-1:0]   SWIN_RST  = 4'd3;

  // Register port geometry.
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARSE_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_WINDOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_WINDOW = 3'd4;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD = 2'd0,
    REQ_FILL = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  localparam logic KIND_FILL_DONE = 1'b0;
  localparam logic KIND_READ_DATA = 1'b1;

  // Q0.16 inverse distance for squared distance s: the largest w with
  // (2w-1)^2 * s <= 2^34, saturated to 16 bits. Evaluated at elaboration.
  function automatic logic [DEPTH_W-1:0] weight_of(input int unsigned s);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned t;
    lo = 1;
    hi = 65536;
    if (s == 0) begin
      return '0;
    end
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      t   = 2 * mid - 1;
      if (t * t * longint'(s) <= (64'd1 << 34)) lo = mid;
      else hi = mid - 1;
    end
    if (lo > 65535) lo = 65535;
    return lo[DEPTH_W-1:0];
  endfunction

endpackage

@@ hw/rtl/aihf_if.sv @@
// Request and response channel interfaces of the hole-fill block.
interface aihf_req_if import aihf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [DEPTH_W-1:0] depth_in;

  modport source (output valid, output req_type, output depth_in, input ready);
  modport sink (input valid, input req_type, input depth_in, output ready);
endinterface

interface aihf_rsp_if import aihf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [DEPTH_W-1:0] depth_out;
  logic               last_pixel;

  modport source (output valid, output result_kind, output depth_out, output last_pixel,
                  input ready);
  modport sink (input valid, input result_kind, input depth_out, input last_pixel,
                output ready);
endinterface

@@ hw/rtl/adaptive_idw_hole_fill.sv @@
// Top level of the adaptive inverse-distance-weighted depth hole filler.
//
// Usage: requests arrive on req_i (valid/ready). A load writes depth_in at the next raster
// position and gives no result. A read returns the next raster pixel on rsp_o, with
// last_pixel set for the final pixel of the frame. A fill request walks all interior
// pixels in place and returns one fill-finished transaction when the walk ends.
// The image size and window settings are to be written over the APB-style port while idle;
// the block itself does not enforce this. A read goes through the registered read of the
// single-port depth memory and then the output register. A fill skips each interior pixel
// that is already known; for a hole it visits the 9 pixels of its 3x3 neighborhood, then
// each in-range pixel of its chosen window, then runs the shared divider and writes the
// result, unless no pixel of the window is known. The single memory port and the one
// multiply-accumulate path carry all window visits, so fill time grows with hole count
// and window area.
// Reset returns load and read positions to zero and the registers to their defaults;
// the depth memory is not cleared and must be loaded before it is read.
// When the receiver stalls, a finished transaction waits in the output register and new
// requests are held off until it is taken.
`include "adaptive_idw_hole_fill_defines.svh"

module adaptive_idw_hole_fill
  import aihf_pkg::*;
#(
  parameter int unsigned MAX_ROWS   = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS   = DEF_MAX_COLS,
  parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  aihf_req_if.sink              req_i,
  aihf_rsp_if.source            rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SZW   = $clog2(DEPTH + 1);
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned CW    = $clog2(MAX_COLS + 1);
  localparam int unsigned WW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned NE    = (2 * MAX_WINDOW + 1) * (2 * MAX_WINDOW + 1);
  localparam int unsigned NW    = $clog2(NE + 1);
  localparam int unsigned WSW   = DEPTH_W + NW;
  localparam int unsigned VSW   = 2 * DEPTH_W + NW;
  localparam int unsigned NCW   = 4;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_TEST, S_SETUP, S_RD, S_MUL, S_ACC,
    S_PICK, S_DIVCHK, S_DIV, S_WR, S_NEXT, S_DONE
  } state_e;

  // Configuration registers hold raw bits; effective values are saturated.
  logic [ROWS_REG_W-1:0]  rows_raw_q;
  logic [COLS_REG_W-1:0]  cols_raw_q;
  logic [LIMIT_REG_W-1:0] limit_q;
  logic [WIN_REG_W-1:0]   lwin_raw_q;
  logic [WIN_REG_W-1:0]   swin_raw_q;
  logic [RW-1:0]          rows_eff;
  logic [CW-1:0]          cols_eff;
  logic [WW-1:0]          lwin_eff;
  logic [WW-1:0]          swin_eff;
  logic [SZW-1:0]         size;
  logic                   cfg_wr;

  assign rows_eff = (32'(rows_raw_q) < 32'd3) ? RW'(3) :
                    (32'(rows_raw_q) > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_raw_q);
  assign cols_eff = (32'(cols_raw_q) < 32'd3) ? CW'(3) :
                    (32'(cols_raw_q) > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols_raw_q);
  assign lwin_eff = (32'(lwin_raw_q) < 32'd1) ? WW'(1) :
                    (32'(lwin_raw_q) > 32'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : WW'(lwin_raw_q);
  assign swin_eff = (32'(swin_raw_q) < 32'd1) ? WW'(1) :
                    (32'(swin_raw_q) > 32'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : WW'(swin_raw_q);
  assign size     = SZW'(rows_eff) * SZW'(cols_eff);

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_raw_q <= ROWS_RST;
      cols_raw_q <= COLS_RST;
      limit_q    <= LIMIT_RST;
      lwin_raw_q <= LWIN_RST;
      swin_raw_q <= SWIN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[CFG_IDX_W+1:2])
        REG_IMAGE_ROWS:   rows_raw_q <= pwdata[ROWS_REG_W-1:0];
        REG_IMAGE_COLS:   cols_raw_q <= pwdata[COLS_REG_W-1:0];
        REG_SPARSE_LIMIT: limit_q    <= pwdata[LIMIT_REG_W-1:0];
        REG_LARGE_WINDOW: lwin_raw_q <= pwdata[WIN_REG_W-1:0];
        REG_SMALL_WINDOW: swin_raw_q <= pwdata[WIN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[CFG_IDX_W+1:2])
      REG_IMAGE_ROWS:   prdata = CFG_DATA_W'(rows_raw_q);
      REG_IMAGE_COLS:   prdata = CFG_DATA_W'(cols_raw_q);
      REG_SPARSE_LIMIT: prdata = CFG_DATA_W'(limit_q);
      REG_LARGE_WINDOW: prdata = CFG_DATA_W'(lwin_raw_q);
      REG_SMALL_WINDOW: prdata = CFG_DATA_W'(swin_raw_q);
      default:          prdata = '0;
    endcase
  end

  // Inverse-distance weights indexed by absolute row and column offset.
  logic [DEPTH_W-1:0] wtab [MAX_WINDOW+1][MAX_WINDOW+1];

  for (genvar r = 0; r <= MAX_WINDOW; r++) begin : g_wrow
    for (genvar c = 0; c <= MAX_WINDOW; c++) begin : g_wcol
      assign wtab[r][c] = weight_of(r * r + c * c);
    end
  end

  state_e             state_q;
  logic [AW-1:0]      ld_pos_q;
  logic [AW-1:0]      rd_pos_q;
  logic               rd_pend_q;
  logic               rd_last_q;
  logic               out_valid_q;
  logic               out_kind_q;
  logic [DEPTH_W-1:0] out_depth_q;
  logic               out_last_q;

  // Fill walk state: current pixel, window bounds and accumulators.
  logic [RW-1:0]      i_q;
  logic [CW-1:0]      j_q;
  logic [AW-1:0]      idx_q;
  logic [WW-1:0]      win_q;
  logic               cnt_mode_q;
  logic [RW-1:0]      ni_q;
  logic [RW-1:0]      ni1_q;
  logic [CW-1:0]      nj_q;
  logic [CW-1:0]      nj0_q;
  logic [CW-1:0]      nj1_q;
  logic [AW-1:0]      base_q;
  logic [DEPTH_W-1:0] wt_q;
  logic [2*DEPTH_W-1:0] prod_q;
  logic               nz_q;
  logic [NCW-1:0]     nbr_cnt_q;
  logic [VSW-1:0]     vsum_q;
  logic [WSW-1:0]     wsum_q;

  logic               in_ready;
  logic               in_acc;
  logic               fill_out;
  logic [AW-1:0]      ld_p;
  logic [AW-1:0]      rd_p;
  logic               rd_last;
  logic [AW-1:0]      ld_next;
  logic [AW-1:0]      ram_addr;
  logic               ram_we;
  logic [DEPTH_W-1:0] ram_wdata;
  logic [DEPTH_W-1:0] ram_rdata;
  logic               div_start;
  logic               div_done;
  logic [DEPTH_W-1:0] div_quot;

  assign in_ready = (state_q == S_IDLE) && !rd_pend_q && (!out_valid_q || rsp_o.ready);
  assign in_acc   = req_i.valid && in_ready;
  assign req_i.ready = in_ready;

  // The fill-finished transaction goes out once the output register is free.
  assign fill_out = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  // Positions at or past the frame size (after a resize) restart at zero.
  assign ld_p    = (SZW'(ld_pos_q) >= size) ? '0 : ld_pos_q;
  assign rd_p    = (SZW'(rd_pos_q) >= size) ? '0 : rd_pos_q;
  assign ld_next = (SZW'(ld_p) + SZW'(1) >= size) ? '0 : ld_p + AW'(1);
  assign rd_last = (SZW'(rd_p) + SZW'(1) >= size);

  // Window bounds for the current pixel, clipped at the image edges.
  logic [31:0] i32, j32, w32, ni0_32, ni1_32, nj0_32, nj1_32;
  logic [WW-1:0] dr_setup;
  logic [AW-1:0] base_setup;
  logic [WW-1:0] dr_rd;
  logic [WW-1:0] dc_rd;
  logic          walk_last;

  always_comb begin
    i32    = 32'(i_q);
    j32    = 32'(j_q);
    w32    = 32'(win_q);
    ni0_32 = (i32 > w32) ? i32 - w32 : 32'd0;
    ni1_32 = (i32 + w32 > 32'(rows_eff) - 32'd1) ? 32'(rows_eff) - 32'd1 : i32 + w32;
    nj0_32 = (j32 > w32) ? j32 - w32 : 32'd0;
    nj1_32 = (j32 + w32 > 32'(cols_eff) - 32'd1) ? 32'(cols_eff) - 32'd1 : j32 + w32;
  end

  // Raster address of column zero in the first window row.
  assign dr_setup   = WW'(i32 - ni0_32);
  assign base_setup = idx_q - AW'(dr_setup) * AW'(cols_eff) - AW'(j_q);

  assign dr_rd     = (ni_q >= i_q) ? WW'(ni_q - i_q) : WW'(i_q - ni_q);
  assign dc_rd     = (nj_q >= j_q) ? WW'(nj_q - j_q) : WW'(j_q - nj_q);
  assign walk_last = (nj_q == nj1_q) && (ni_q == ni1_q);

  always_comb begin
    ram_addr  = idx_q;
    ram_we    = 1'b0;
    ram_wdata = div_quot;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && req_i.req_type == REQ_LOAD) begin
          ram_addr  = ld_p;
          ram_we    = 1'b1;
          ram_wdata = req_i.depth_in;
        end else if (in_acc && req_i.req_type == REQ_READ) begin
          ram_addr = rd_p;
        end
      end
      S_RD: ram_addr = base_q + AW'(nj_q);
      S_WR: ram_we = 1'b1;
      default: ;
    endcase
  end

  assign div_start = (state_q == S_DIVCHK) && (wsum_q != '0);

  aihf_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  aihf_div #(
    .DVD_W (VSW),
    .DSR_W (WSW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (vsum_q),
    .divisor_i  (wsum_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ld_pos_q    <= '0;
      rd_pos_q    <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_FILL_DONE;
      out_depth_q <= '0;
      out_last_q  <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      idx_q       <= '0;
      win_q       <= '0;
      cnt_mode_q  <= 1'b0;
      ni_q        <= '0;
      ni1_q       <= '0;
      nj_q        <= '0;
      nj0_q       <= '0;
      nj1_q       <= '0;
      base_q      <= '0;
      wt_q        <= '0;
      prod_q      <= '0;
      nz_q        <= 1'b0;
      nbr_cnt_q   <= '0;
      vsum_q      <= '0;
      wsum_q      <= '0;
    end else begin
      rd_pend_q <= in_acc && (req_i.req_type == REQ_READ);
      if (rd_pend_q || fill_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      // Read data arrives in the cycle after the address went to the memory.
      if (rd_pend_q) begin
        out_kind_q  <= KIND_READ_DATA;
        out_depth_q <= ram_rdata;
        out_last_q  <= rd_last_q;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (req_i.req_type)
              REQ_LOAD: ld_pos_q <= ld_next;
              REQ_READ: begin
                rd_last_q <= rd_last;
                rd_pos_q  <= rd_last ? '0 : rd_p + AW'(1);
              end
              REQ_FILL: begin
                i_q     <= RW'(1);
                j_q     <= CW'(1);
                idx_q   <= AW'(cols_eff) + AW'(1);
                state_q <= S_CHK;
              end
              default: ;
            endcase
          end
        end
        S_CHK: state_q <= S_TEST;
        S_TEST: begin
          if (ram_rdata != '0) begin
            state_q <= S_NEXT;
          end else begin
            win_q      <= WW'(1);
            cnt_mode_q <= 1'b1;
            nbr_cnt_q  <= '0;
            state_q    <= S_SETUP;
          end
        end
        S_SETUP: begin
          ni_q    <= RW'(ni0_32);
          ni1_q   <= RW'(ni1_32);
          nj_q    <= CW'(nj0_32);
          nj0_q   <= CW'(nj0_32);
          nj1_q   <= CW'(nj1_32);
          base_q  <= base_setup;
          state_q <= S_RD;
        end
        S_RD: begin
          wt_q    <= wtab[dr_rd][dc_rd];
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q  <= wt_q * ram_rdata;
          nz_q    <= (ram_rdata != '0);
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (cnt_mode_q) begin
            nbr_cnt_q <= nbr_cnt_q + NCW'(nz_q);
          end else if (nz_q) begin
            vsum_q <= vsum_q + VSW'(prod_q);
            wsum_q <= wsum_q + WSW'(wt_q);
          end
          if (walk_last) begin
            state_q <= cnt_mode_q ? S_PICK : S_DIVCHK;
          end else begin
            state_q <= S_RD;
            if (nj_q == nj1_q) begin
              nj_q   <= nj0_q;
              ni_q   <= ni_q + RW'(1);
              base_q <= base_q + AW'(cols_eff);
            end else begin
              nj_q <= nj_q + CW'(1);
            end
          end
        end
        S_PICK: begin
          win_q      <= (nbr_cnt_q < limit_q) ? lwin_eff : swin_eff;
          cnt_mode_q <= 1'b0;
          vsum_q     <= '0;
          wsum_q     <= '0;
          state_q    <= S_SETUP;
        end
        S_DIVCHK: state_q <= (wsum_q == '0) ? S_NEXT : S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_q <= S_WR;
          end
        end
        S_WR: state_q <= S_NEXT;
        S_NEXT: begin
          if (j_q == cols_eff - CW'(2)) begin
            if (i_q == rows_eff - RW'(2)) begin
              state_q <= S_DONE;
            end else begin
              i_q     <= i_q + RW'(1);
              j_q     <= CW'(1);
              idx_q   <= idx_q + AW'(3);
              state_q <= S_CHK;
            end
          end else begin
            j_q     <= j_q + CW'(1);
            idx_q   <= idx_q + AW'(1);
            state_q <= S_CHK;
          end
        end
        S_DONE: begin
          if (fill_out) begin
            out_kind_q  <= KIND_FILL_DONE;
            out_depth_q <= '0;
            out_last_q  <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.result_kind = out_kind_q;
  assign rsp_o.depth_out   = out_depth_q;
  assign rsp_o.last_pixel  = out_last_q;

  `AIHF_ASSERT_IMP(a_rd_slot_free, clk_i, rst_ni, rd_pend_q, !out_valid_q, "read data has no free output slot")
  `AIHF_ASSERT_IMP(a_fill_wr_only, clk_i, rst_ni, (state_q != S_IDLE) && ram_we, state_q == S_WR, "stray memory write during fill")
  `AIHF_ASSERT_IMP(a_walk_bounds, clk_i, rst_ni, state_q == S_RD, (ni_q <= ni1_q) && (nj_q >= nj0_q) && (nj_q <= nj1_q), "window walk left its bounds")
  `AIHF_ASSERT_NXT(a_div_follows, clk_i, rst_ni, div_start, state_q == S_DIV, "divider started outside the divide step")

endmodule

@@ hw/rtl/aihf_ram.sv @@
// Generic single-port RAM with registered read data.
module aihf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/aihf_div.sv @@
// Restoring divider, one quotient bit per cycle, for the weighted mean.
`include "adaptive_idw_hole_fill_defines.svh"

module aihf_div
  import aihf_pkg::*;
#(
  parameter int unsigned DVD_W = 41,
  parameter int unsigned DSR_W = 25
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DVD_W-1:0]   dividend_i,
  input  logic [DSR_W-1:0]   divisor_i,
  output logic               done_o,
  output logic [DEPTH_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH_W);

  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DVD_W-1:0]   rem_q;
  logic [DVD_W-1:0]   dvs_q;
  logic [DSR_W-1:0]   dsr_q;
  logic [DEPTH_W-1:0] quot_q;
  logic               ge;

  // The quotient is known to fit in DEPTH_W bits, so the divisor starts
  // shifted up by DEPTH_W-1 and walks down one bit each cycle.
  assign ge = (rem_q >= dvs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      dsr_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DEPTH_W - 1);
        rem_q  <= dividend_i;
        dvs_q  <= DVD_W'(divisor_i) << (DEPTH_W - 1);
        dsr_q  <= divisor_i;
        quot_q <= '0;
      end else if (busy_q) begin
        if (ge) begin
          rem_q <= rem_q - dvs_q;
        end
        quot_q <= {quot_q[DEPTH_W-2:0], ge};
        dvs_q  <= dvs_q >> 1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  `AIHF_ASSERT_IMP(a_div_no_restart, clk_i, rst_ni, start_i, !busy_q, "divider restarted while busy")
  `AIHF_ASSERT_NXT(a_div_starts, clk_i, rst_ni, start_i, busy_q, "divider did not start")
  `AIHF_ASSERT_IMP(a_div_rem_small, clk_i, rst_ni, done_q, rem_q < DVD_W'(dsr_q), "remainder not below divisor")

endmodule
